// ----- hdl/prtt_pkg.sv -----
`timescale 1ns / 1ps

package prtt_pkg;

   // Field widths of the request and response transfers
   localparam int ReqW   = 3;
   localparam int PortW  = 4;
   localparam int StampW = 48;
   localparam int RttW   = 32;

   // Number of slots that a port index can address
   localparam int PortSpan = 16;

   typedef logic [ReqW-1:0]          req_code_type;
   typedef logic [PortW-1:0]         port_type;
   typedef logic [StampW-1:0]        stamp_type;
   typedef logic signed [RttW-1:0]   rtt_type;

   // Request codes
   localparam req_code_type REQ_PING      = 3'd0;
   localparam req_code_type REQ_PONG      = 3'd1;
   localparam req_code_type REQ_READ_PORT = 3'd2;
   localparam req_code_type REQ_READ_AVG  = 3'd3;
   localparam req_code_type REQ_READ_RANK = 3'd4;

   // Value reported when an RTT is unknown
   localparam rtt_type RTT_UNKNOWN = -32'sd1;
   localparam rtt_type RTT_MAX     = 32'sh7fff_ffff;
   localparam rtt_type RTT_MIN     = 32'sh8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_AVG_SCAN,
      ST_AVG_DIV,
      ST_AVG_OUT,
      ST_RANK_SCAN,
      ST_RANK_OUT
   } state_type;

endpackage

// ----- hdl/port_rtt_tracker_ranker_core.sv -----
`timescale 1ns / 1ps

// Ping and pong take effect in the cycle they transfer; the block is ready again next cycle.
// Read port: the index is registered, then the result once the response register is free.
// Average: slot scan plus a bit-serial divider.
// Ranking: one min-search scan of the table per result.
// Synchronous active-high reset clears all pending and RTT valid bits at once.
module port_rtt_tracker_ranker_core #(
   parameter int NUM_PORTS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  prtt_pkg::req_code_type req_type,
   input  prtt_pkg::port_type     req_port_index,
   input  prtt_pkg::stamp_type    req_time_stamp,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output prtt_pkg::port_type     rsp_port_out,
   output prtt_pkg::rtt_type      rsp_rtt_value,
   output logic                   rsp_known,
   output logic                   rsp_last
);
   import prtt_pkg::*;

   localparam int NumSlots = (NUM_PORTS < PortSpan) ? NUM_PORTS : PortSpan;
   localparam int IdxW     = $clog2(NumSlots);
   localparam int CntW     = $clog2(NumSlots + 1);
   localparam int SumW     = RttW - 1 + CntW;
   localparam int StepW    = $clog2(SumW);
   localparam int KeyW     = RttW + IdxW;
   localparam int DiffW    = StampW + 1;

   // Table storage
   stamp_type               pending_stamp_ff [NumSlots];
   rtt_type                 latest_rtt_ff    [NumSlots];
   logic [NumSlots-1:0]     pending_valid_ff, pending_valid_in;
   logic [NumSlots-1:0]     rtt_valid_ff, rtt_valid_in;
   logic                    stamp_we, rtt_we;
   rtt_type                 latest_rtt_in;

   // Sequencer state
   state_type               state_ff, state_in;
   port_type                port_ff, port_in;
   logic                    inrange_ff, inrange_in;
   logic [IdxW-1:0]         scan_ff, scan_in;
   logic [SumW-1:0]         sum_ff, sum_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;
   logic [CntW-1:0]         rem_ff, rem_in;
   logic [StepW-1:0]        step_ff, step_in;
   rtt_type                 best_rtt_ff, best_rtt_in;
   logic [IdxW-1:0]         best_port_ff, best_port_in;
   logic                    found_ff, found_in;
   rtt_type                 prev_rtt_ff, prev_rtt_in;
   logic [IdxW-1:0]         prev_port_ff, prev_port_in;
   logic                    have_prev_ff, have_prev_in;
   logic [CntW-1:0]         emit_cnt_ff, emit_cnt_in;

   // Response register
   logic                    rsp_valid_ff, rsp_valid_in;
   port_type                rsp_port_ff, rsp_port_in;
   rtt_type                 rsp_rtt_ff, rsp_rtt_in;
   logic                    rsp_known_ff, rsp_known_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Helpers
   logic                    accept;
   logic                    req_inrange;
   logic [IdxW-1:0]         req_idx;
   logic [IdxW-1:0]         rd_idx;
   rtt_type                 rd_rtt;
   logic                    rd_valid;
   logic                    out_free;
   logic                    scan_end;
   logic                    avg_hit;
   logic                    div_done;
   logic                    rank_last;
   logic                    rank_take;
   logic [KeyW-1:0]         rd_key, best_key, prev_key;
   logic [DiffW-1:0]        pong_diff;
   logic [CntW:0]           div_shift;
   logic [CntW:0]           div_sub;
   logic                    div_bit;
   logic [CntW-1:0]         valid_total;

   // Ordering key: signed RTT made unsigned, then slot number for ties
   function automatic logic [KeyW-1:0] rank_key(input rtt_type rtt,
                                                input logic [IdxW-1:0] idx);
      rank_key = {~rtt[RttW-1], rtt[RttW-2:0], idx};
   endfunction

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign req_inrange = ({1'b0, req_port_index} < (PortW + 1)'(NumSlots));
   assign req_idx     = req_port_index[IdxW-1:0];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign scan_end    = (scan_ff == IdxW'(NumSlots - 1));
   assign div_done    = (step_ff == '0);

   // Single read port into the RTT table
   assign rd_idx   = (state_ff == ST_READ) ? port_ff[IdxW-1:0] : scan_ff;
   assign rd_rtt   = latest_rtt_ff[rd_idx];
   assign rd_valid = rtt_valid_ff[rd_idx];

   // Average accumulates only positive RTTs
   assign avg_hit = rd_valid && !rd_rtt[RttW-1] && (rd_rtt != '0);

   // Ranking compare: next key above the previous one and below the best so far
   assign rd_key    = rank_key(rd_rtt, scan_ff);
   assign best_key  = rank_key(best_rtt_ff, best_port_ff);
   assign prev_key  = rank_key(prev_rtt_ff, prev_port_ff);
   assign rank_take = rd_valid && (!have_prev_ff || (rd_key > prev_key))
                      && (!found_ff || (rd_key < best_key));
   assign rank_last = !found_ff || (CntW'(emit_cnt_ff + 1'b1) == cnt_ff);

   // Pong difference, exact over 49 bits
   assign pong_diff = {1'b0, req_time_stamp} - {1'b0, pending_stamp_ff[req_idx]};

   // Restoring divider step
   assign div_shift = {rem_ff, sum_ff[SumW-1]};
   assign div_bit   = (div_shift >= {1'b0, cnt_ff});
   assign div_sub   = div_shift - {1'b0, cnt_ff};

   // Known-port count for the ranking
   always_comb begin
      valid_total = '0;
      for (int i = 0; i < NumSlots; i++) begin
         valid_total = valid_total + CntW'(rtt_valid_ff[i]);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_READ_PORT: state_in = ST_READ;
                  REQ_READ_AVG:  state_in = ST_AVG_SCAN;
                  REQ_READ_RANK: state_in = ST_RANK_SCAN;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_AVG_SCAN: begin
            if (scan_end) begin
               state_in = ((cnt_ff != '0) || avg_hit) ? ST_AVG_DIV : ST_AVG_OUT;
            end
         end
         ST_AVG_DIV: begin
            if (div_done) state_in = ST_AVG_OUT;
         end
         ST_AVG_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_RANK_SCAN: begin
            if (scan_end) state_in = ST_RANK_OUT;
         end
         ST_RANK_OUT: begin
            if (out_free) state_in = rank_last ? ST_IDLE : ST_RANK_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      pending_valid_in = pending_valid_ff;
      rtt_valid_in     = rtt_valid_ff;
      stamp_we         = 1'b0;
      rtt_we           = 1'b0;
      latest_rtt_in    = pong_diff[RttW-1:0];
      port_in          = port_ff;
      inrange_in       = inrange_ff;
      scan_in          = scan_ff;
      sum_in           = sum_ff;
      cnt_in           = cnt_ff;
      rem_in           = rem_ff;
      step_in          = step_ff;
      best_rtt_in      = best_rtt_ff;
      best_port_in     = best_port_ff;
      found_in         = found_ff;
      prev_rtt_in      = prev_rtt_ff;
      prev_port_in     = prev_port_ff;
      have_prev_in     = have_prev_ff;
      emit_cnt_in      = emit_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_port_in      = rsp_port_ff;
      rsp_rtt_in       = rsp_rtt_ff;
      rsp_known_in     = rsp_known_ff;
      rsp_last_in      = rsp_last_ff;

      // Saturate the pong difference to signed 32 bits
      if (!((pong_diff[DiffW-1:RttW-1] == '0) || (pong_diff[DiffW-1:RttW-1] == '1))) begin
         latest_rtt_in = pong_diff[DiffW-1] ? RTT_MIN : RTT_MAX;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_PING: begin
                     if (req_inrange) begin
                        stamp_we                  = 1'b1;
                        pending_valid_in[req_idx] = 1'b1;
                     end
                  end
                  REQ_PONG: begin
                     if (req_inrange && pending_valid_ff[req_idx]) begin
                        rtt_we                    = 1'b1;
                        rtt_valid_in[req_idx]     = 1'b1;
                        pending_valid_in[req_idx] = 1'b0;
                     end
                  end
                  REQ_READ_PORT: begin
                     port_in    = req_port_index;
                     inrange_in = req_inrange;
                  end
                  REQ_READ_AVG: begin
                     scan_in = '0;
                     sum_in  = '0;
                     cnt_in  = '0;
                  end
                  REQ_READ_RANK: begin
                     scan_in      = '0;
                     found_in     = 1'b0;
                     have_prev_in = 1'b0;
                     emit_cnt_in  = '0;
                     cnt_in       = valid_total;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_port_in  = port_ff;
               rsp_last_in  = 1'b1;
               if (inrange_ff && rd_valid) begin
                  rsp_rtt_in   = rd_rtt;
                  rsp_known_in = 1'b1;
               end else begin
                  rsp_rtt_in   = RTT_UNKNOWN;
                  rsp_known_in = 1'b0;
               end
            end
         end
         ST_AVG_SCAN: begin
            if (avg_hit) begin
               sum_in = sum_ff + SumW'(rd_rtt[RttW-2:0]);
               cnt_in = cnt_ff + 1'b1;
            end
            scan_in = scan_ff + 1'b1;
            rem_in  = '0;
            step_in = StepW'(SumW - 1);
         end
         ST_AVG_DIV: begin
            // One quotient bit per cycle, shifted into the sum register
            rem_in  = div_bit ? div_sub[CntW-1:0] : div_shift[CntW-1:0];
            sum_in  = {sum_ff[SumW-2:0], div_bit};
            step_in = step_ff - 1'b1;
         end
         ST_AVG_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_port_in  = '0;
               rsp_last_in  = 1'b1;
               if (cnt_ff != '0) begin
                  rsp_rtt_in   = sum_ff[RttW-1:0];
                  rsp_known_in = 1'b1;
               end else begin
                  rsp_rtt_in   = RTT_UNKNOWN;
                  rsp_known_in = 1'b0;
               end
            end
         end
         ST_RANK_SCAN: begin
            if (rank_take) begin
               best_rtt_in  = rd_rtt;
               best_port_in = scan_ff;
               found_in     = 1'b1;
            end
            scan_in = scan_ff + 1'b1;
         end
         ST_RANK_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = rank_last;
               if (found_ff) begin
                  rsp_port_in  = PortW'(best_port_ff);
                  rsp_rtt_in   = best_rtt_ff;
                  rsp_known_in = 1'b1;
               end else begin
                  rsp_port_in  = '0;
                  rsp_rtt_in   = RTT_UNKNOWN;
                  rsp_known_in = 1'b0;
               end
               // Set up the next pass above the port just sent
               prev_rtt_in  = best_rtt_ff;
               prev_port_in = best_port_ff;
               have_prev_in = 1'b1;
               found_in     = 1'b0;
               emit_cnt_in  = emit_cnt_ff + 1'b1;
               scan_in      = '0;
            end
         end
         default: ;
      endcase
   end

   // Table entries, written without reset
   always_ff @(posedge clock) begin
      if (stamp_we) pending_stamp_ff[req_idx] <= req_time_stamp;
      if (rtt_we)   latest_rtt_ff[req_idx]    <= latest_rtt_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         pending_valid_ff <= '0;
         rtt_valid_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pending_valid_ff <= pending_valid_in;
         rtt_valid_ff     <= rtt_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      port_ff      <= port_in;
      inrange_ff   <= inrange_in;
      scan_ff      <= scan_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      best_rtt_ff  <= best_rtt_in;
      best_port_ff <= best_port_in;
      found_ff     <= found_in;
      prev_rtt_ff  <= prev_rtt_in;
      prev_port_ff <= prev_port_in;
      have_prev_ff <= have_prev_in;
      emit_cnt_ff  <= emit_cnt_in;
      rsp_port_ff  <= rsp_port_in;
      rsp_rtt_ff   <= rsp_rtt_in;
      rsp_known_ff <= rsp_known_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_port_out  = rsp_port_ff;
   assign rsp_rtt_value = rsp_rtt_ff;
   assign rsp_known     = rsp_known_ff;
   assign rsp_last      = rsp_last_ff;

   // An unknown result always carries the unknown marker
   a_unknown_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_known_ff) |-> (rsp_rtt_ff == RTT_UNKNOWN))
      else $error("unknown result without unknown marker");

   // Divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AVG_DIV) |-> (rem_ff < cnt_ff))
      else $error("divider remainder out of range");

   // A known average is never negative
   a_avg_sign: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AVG_OUT && out_free && cnt_ff != '0) |=> !rsp_rtt_ff[RttW-1])
      else $error("negative average");

   // Ranking never sends more entries than known ports
   a_rank_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RANK_OUT && found_ff) |-> (emit_cnt_ff < cnt_ff))
      else $error("ranking overran known port count");

   // Ranking output is in strictly ascending key order
   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RANK_OUT && found_ff && have_prev_ff) |-> (best_key > prev_key))
      else $error("ranking out of order");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import prtt_pkg::*;

   localparam int NUM_PORTS   = PortSpan;
   localparam int RAND_ITEMS  = 405;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_WAIT  = 320;
   localparam int EXP_DEPTH   = 1024;

   // request codes the block drops without a response
   localparam req_code_type REQ_UNUSED_5 = 3'd5;
   localparam req_code_type REQ_UNUSED_6 = 3'd6;
   localparam req_code_type REQ_UNUSED_7 = 3'd7;

   localparam stamp_type STAMP_MAX = {StampW{1'b1}};

   typedef struct packed {
      port_type port_out;
      rtt_type  rtt_value;
      logic     known;
      logic     last;
   } rtt_beat_type;

   typedef struct packed {
      req_code_type code;
      port_type     port;
      stamp_type    stamp;
      logic         typed;
      rtt_beat_type want;
   } dir_row_type;

   localparam rtt_beat_type NO_BEAT = '0;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_code_type req_type = REQ_PING;
   port_type     req_port_index = '0;
   stamp_type    req_time_stamp = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   port_type     rsp_port_out;
   rtt_type      rsp_rtt_value;
   logic         rsp_known;
   logic         rsp_last;

   // expectation typed into the directed table, travels with the request
   logic         row_typed = 1'b0;
   rtt_beat_type row_want = '0;

   // predictor state
   stamp_type ping_stamp [NUM_PORTS];
   logic      ping_open  [NUM_PORTS];
   rtt_type   port_rtt   [NUM_PORTS];
   logic      rtt_seen   [NUM_PORTS];

   // expected responses, in order: ring with free-running write and read counts
   rtt_beat_type exp_fifo [EXP_DEPTH];
   int           exp_wr = 0;
   int           exp_rd = 0;

   int  errors = 0;
   int  n_req = 0;
   int  n_rsp = 0;
   int  n_rank = 0;
   int  n_sat = 0;
   int  longest_rank = 0;
   int  idle_count = 0;
   bit  hold_off_go = 1'b0;
   bit  hold_off_done = 1'b0;

   dir_row_type dir_rows [25];

   port_rtt_tracker_ranker_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_port_index (req_port_index),
      .req_time_stamp (req_time_stamp),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_port_out   (rsp_port_out),
      .rsp_rtt_value  (rsp_rtt_value),
      .rsp_known      (rsp_known),
      .rsp_last       (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Append one expected response
   function automatic void queue_beat(input port_type po, input rtt_type rv,
                                      input logic kn, input logic la);
      rtt_beat_type b;
      b.port_out = po;
      b.rtt_value = rv;
      b.known = kn;
      b.last = la;
      exp_fifo[exp_wr % EXP_DEPTH] = b;
      exp_wr++;
   endfunction

   // Remove the oldest expected response
   function automatic rtt_beat_type take_beat();
      rtt_beat_type b;
      b = exp_fifo[exp_rd % EXP_DEPTH];
      exp_rd++;
      return b;
   endfunction

   // Update the RTT table for one request; queue its responses if asked.
   task automatic rtt_table_apply(input req_code_type code, input port_type p,
                                  input stamp_type ts, input bit queue_rsp);
      longint diff;
      longint sum;
      int     cnt;
      int     order [NUM_PORTS];
      int     n;
      int     j;
      bit     in_range;
      in_range = int'(p) < NUM_PORTS;
      case (code)
         REQ_PING: begin
            if (in_range) begin
               ping_stamp[p] = ts;
               ping_open[p]  = 1'b1;
            end
         end
         REQ_PONG: begin
            if (in_range && ping_open[p]) begin
               diff = longint'(ts) - longint'(ping_stamp[p]);
               if (diff > longint'(RTT_MAX)) begin
                  port_rtt[p] = RTT_MAX;
                  n_sat++;
               end else if (diff < longint'(RTT_MIN)) begin
                  port_rtt[p] = RTT_MIN;
                  n_sat++;
               end else begin
                  port_rtt[p] = rtt_type'(diff);
               end
               rtt_seen[p]  = 1'b1;
               ping_open[p] = 1'b0;
            end
         end
         REQ_READ_PORT: begin
            if (queue_rsp) begin
               if (in_range && rtt_seen[p])
                  queue_beat(p, port_rtt[p], 1'b1, 1'b1);
               else
                  queue_beat(p, RTT_UNKNOWN, 1'b0, 1'b1);
            end
         end
         REQ_READ_AVG: begin
            sum = 0;
            cnt = 0;
            for (int i = 0; i < NUM_PORTS; i++) begin
               if (rtt_seen[i] && port_rtt[i] > 0) begin
                  sum += longint'(port_rtt[i]);
                  cnt++;
               end
            end
            if (queue_rsp) begin
               if (cnt > 0)
                  queue_beat(port_type'(0), rtt_type'(sum / cnt), 1'b1, 1'b1);
               else
                  queue_beat(port_type'(0), RTT_UNKNOWN, 1'b0, 1'b1);
            end
         end
         REQ_READ_RANK: begin
            // stable insertion sort: only a strictly larger RTT is pushed back
            n = 0;
            for (int i = 0; i < NUM_PORTS; i++) begin
               if (rtt_seen[i]) begin
                  j = n;
                  while (j > 0 && port_rtt[order[j-1]] > port_rtt[i]) begin
                     order[j] = order[j-1];
                     j--;
                  end
                  order[j] = i;
                  n++;
               end
            end
            n_rank++;
            if (n > longest_rank) longest_rank = n;
            if (queue_rsp) begin
               if (n == 0)
                  queue_beat(port_type'(0), RTT_UNKNOWN, 1'b0, 1'b1);
               for (int k = 0; k < n; k++)
                  queue_beat(port_type'(order[k]), port_rtt[order[k]], 1'b1, k == n - 1);
            end
         end
         default: ;
      endcase
   endtask

   // Request side: predict on every transfer. Response side: check in order.
   always @(posedge clock) begin
      rtt_beat_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            n_req++;
            rtt_table_apply(req_type, req_port_index, req_time_stamp, !row_typed);
            if (row_typed)
               queue_beat(row_want.port_out, row_want.rtt_value, row_want.known,
                          row_want.last);
         end
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (exp_wr == exp_rd) begin
               errors++;
               $display("%0t: response with nothing expected: port %0d rtt %0d known %0d last %0d",
                        $time, rsp_port_out, rsp_rtt_value, rsp_known, rsp_last);
            end else begin
               want = take_beat();
               if (rsp_port_out !== want.port_out) begin
                  errors++;
                  $display("%0t: port_out expected %0d actual %0d", $time, want.port_out,
                           rsp_port_out);
               end
               if (rsp_rtt_value !== want.rtt_value) begin
                  errors++;
                  $display("%0t: rtt_value expected %0d actual %0d", $time, want.rtt_value,
                           rsp_rtt_value);
               end
               if (rsp_known !== want.known) begin
                  errors++;
                  $display("%0t: known expected %0d actual %0d", $time, want.known, rsp_known);
               end
               if (rsp_last !== want.last) begin
                  errors++;
                  $display("%0t: last expected %0d actual %0d", $time, want.last, rsp_last);
               end
            end
         end
      end
   end

   // Watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
         $display("%0t: timeout, no transfer for %0d cycles, %0d responses outstanding",
                  $time, IDLE_LIMIT, exp_wr - exp_rd);
         $display("FAIL");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // Response consumer: random stall per transfer, quiet stretches, one long hold
   initial begin
      int unsigned stall;
      int          taken;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_go && !hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_done = 1'b1;
         end
         stall = ((taken / 30) % 3 == 1) ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   // Offer one request; called and returns at a falling edge.
   task automatic send_req(input req_code_type code, input port_type p, input stamp_type ts,
                           input logic typed, input rtt_beat_type want, input bit quiet);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= code;
      req_port_index <= p;
      req_time_stamp <= ts;
      row_typed      <= typed;
      row_want       <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic stamp_type rand_stamp();
      if ($urandom_range(0, 1) == 0)
         return stamp_type'($urandom_range(0, 1000000));
      return stamp_type'({$urandom, $urandom});
   endfunction

   // Pong time relative to the open ping: mostly plausible, some saturating
   function automatic stamp_type pong_stamp(input port_type p);
      longint      delta;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)      delta = longint'($urandom_range(0, 20000));
      else if (pick < 65) delta = -longint'($urandom_range(1, 20000));
      else if (pick < 75) delta = 64'sd2147483647 + longint'($urandom_range(0, 2)) - 1;
      else if (pick < 80) delta = -64'sd2147483648 + longint'($urandom_range(0, 2)) - 1;
      else if (pick < 90) delta = longint'({$urandom_range(0, 65535), $urandom});
      else return rand_stamp();
      return stamp_type'(longint'(ping_stamp[p]) + delta);
   endfunction

   task automatic next_random_req(output req_code_type code, output port_type p,
                                  output stamp_type ts);
      int          open_ports [NUM_PORTS];
      int          n_open;
      int unsigned pick;
      n_open = 0;
      pick = $urandom_range(0, 99);
      p    = port_type'($urandom_range(0, NUM_PORTS - 1));
      ts   = rand_stamp();
      if (pick < 30) begin
         code = REQ_PING;
      end else if (pick < 58) begin
         code = REQ_PONG;
         for (int i = 0; i < NUM_PORTS; i++) begin
            if (ping_open[i]) begin
               open_ports[n_open] = i;
               n_open++;
            end
         end
         if (n_open > 0 && $urandom_range(0, 99) < 85) begin
            p  = port_type'(open_ports[$urandom_range(0, n_open - 1)]);
            ts = pong_stamp(p);
         end
      end else if (pick < 73) begin
         code = REQ_READ_PORT;
      end else if (pick < 83) begin
         code = REQ_READ_AVG;
      end else if (pick < 93) begin
         code = REQ_READ_RANK;
      end else begin
         case ($urandom_range(0, 2))
            0:       code = REQ_UNUSED_5;
            1:       code = REQ_UNUSED_6;
            default: code = REQ_UNUSED_7;
         endcase
      end
   endtask

   // Main stimulus: directed table, random traffic, drain and verdict
   initial begin
      req_code_type code;
      port_type     p;
      stamp_type    ts;
      int           made;
      int           offered;

      for (int i = 0; i < NUM_PORTS; i++) begin
         ping_stamp[i] = '0;
         ping_open[i]  = 1'b0;
         port_rtt[i]   = '0;
         rtt_seen[i]   = 1'b0;
      end

      dir_rows = '{
         // empty table: every read reports unknown
         '{REQ_READ_PORT, 4'd0,  48'd0,     1'b1, '{4'd0, RTT_UNKNOWN, 1'b0, 1'b1}},
         '{REQ_READ_AVG,  4'd9,  48'd0,     1'b1, '{4'd0, RTT_UNKNOWN, 1'b0, 1'b1}},
         '{REQ_READ_RANK, 4'd5,  48'd0,     1'b1, '{4'd0, RTT_UNKNOWN, 1'b0, 1'b1}},
         // pong without a ping is dropped
         '{REQ_PONG,      4'd3,  48'd100,   1'b0, NO_BEAT},
         '{REQ_READ_PORT, 4'd3,  48'd0,     1'b1, '{4'd3, RTT_UNKNOWN, 1'b0, 1'b1}},
         // saturation at both ends
         '{REQ_PING,      4'd1,  48'd0,     1'b0, NO_BEAT},
         '{REQ_PONG,      4'd1,  STAMP_MAX, 1'b0, NO_BEAT},
         '{REQ_READ_PORT, 4'd1,  48'd0,     1'b1, '{4'd1, RTT_MAX, 1'b1, 1'b1}},
         '{REQ_PING,      4'd2,  STAMP_MAX, 1'b0, NO_BEAT},
         '{REQ_PONG,      4'd2,  48'd0,     1'b0, NO_BEAT},
         '{REQ_READ_PORT, 4'd2,  48'd0,     1'b1, '{4'd2, RTT_MIN, 1'b1, 1'b1}},
         // second ping overwrites the open stamp
         '{REQ_PING,      4'd15, 48'd1000,  1'b0, NO_BEAT},
         '{REQ_PING,      4'd15, 48'd2000,  1'b0, NO_BEAT},
         '{REQ_PONG,      4'd15, 48'd2500,  1'b0, NO_BEAT},
         '{REQ_READ_PORT, 4'd15, 48'd0,     1'b1, '{4'd15, 32'sd500, 1'b1, 1'b1}},
         // zero RTT is known but left out of the mean
         '{REQ_PING,      4'd0,  48'd7,     1'b0, NO_BEAT},
         '{REQ_PONG,      4'd0,  48'd7,     1'b0, NO_BEAT},
         // tie with port 15: lower port ranks first
         '{REQ_PING,      4'd4,  48'd10,    1'b0, NO_BEAT},
         '{REQ_PONG,      4'd4,  48'd510,   1'b0, NO_BEAT},
         '{REQ_READ_AVG,  4'd0,  48'd0,     1'b0, NO_BEAT},
         '{REQ_READ_RANK, 4'd0,  48'd0,     1'b0, NO_BEAT},
         // reserved codes produce nothing
         '{REQ_UNUSED_5,  4'd0,  48'd0,     1'b0, NO_BEAT},
         '{REQ_UNUSED_6,  4'd8,  48'd1,     1'b0, NO_BEAT},
         '{REQ_UNUSED_7,  4'd15, STAMP_MAX, 1'b0, NO_BEAT},
         '{REQ_READ_PORT, 4'd0,  48'd0,     1'b0, NO_BEAT}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i])
         send_req(dir_rows[i].code, dir_rows[i].port, dir_rows[i].stamp, dir_rows[i].typed,
                  dir_rows[i].want, 1'b0);

      made    = 0;
      offered = 0;
      while (offered < RAND_ITEMS) begin
         next_random_req(code, p, ts);
         if (code <= REQ_READ_RANK) made++;
         // long response hold while requests keep coming
         if (made == 150) hold_off_go = 1'b1;
         send_req(code, p, ts, 1'b0, NO_BEAT, (offered / 40) % 3 == 2);
         offered++;
      end
      req_valid <= 1'b0;

      while (exp_wr != exp_rd) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d requests and %0d responses: %0d rankings (longest %0d ports),",
               n_req, n_rsp, n_rank, longest_rank);
      $display("%0d saturated RTTs, one %0d-cycle response hold.", n_sat, HOLD_CYCLES);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
